/* hw/rtl/cswt_pkg.sv */
// Shared types and constants of the C source word tokenizer.
package cswt_pkg;

  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_HASH       = 8'h23;
  localparam logic [7:0] CH_QUOTE      = 8'h27;
  localparam logic [7:0] CH_DQUOTE     = 8'h22;
  localparam logic [7:0] CH_SLASH      = 8'h2F;
  localparam logic [7:0] CH_STAR       = 8'h2A;
  localparam logic [7:0] CH_BACKSLASH  = 8'h5C;

  localparam logic [7:0] WORD_LIMIT_RESET = 8'd100;

  localparam logic [2:0] K_IDENT   = 3'd0;
  localparam logic [2:0] K_OTHER   = 3'd1;
  localparam logic [2:0] K_CHARLIT = 3'd2;
  localparam logic [2:0] K_STRING  = 3'd3;
  localparam logic [2:0] K_SLASH   = 3'd4;

  typedef struct packed {
    logic [7:0] ch;
    logic       char_valid;
    logic [2:0] kind;
    logic       start_mark;
    logic       end_mark;
    logic       done;
  } cswt_result_t;

  // One queue entry: an optional identifier end marker followed by an optional result.
  typedef struct packed {
    logic         marker;
    logic         present;
    cswt_result_t res;
  } cswt_entry_t;

  localparam cswt_result_t MARKER_RESULT = '{ch: 8'd0, char_valid: 1'b0, kind: K_IDENT,
                                             start_mark: 1'b0, end_mark: 1'b1, done: 1'b0};

endpackage

/* hw/rtl/cswt_front.sv */
// Front part: accepts source bytes, runs the lexer mode machine and builds queue entries.
module cswt_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [7:0]         in_char,
  input  logic               end_of_input,
  input  logic [7:0]         word_limit,
  output logic               push,
  output cswt_pkg::cswt_entry_t entry
);
  import cswt_pkg::*;

  typedef enum logic [2:0] {
    M_IDLE, M_IDENT, M_CHARLIT, M_STRING, M_STR_ESC, M_SLASH, M_COMMENT, M_COMMENT_STAR
  } mode_t;

  mode_t        mode;
  mode_t        mode_next;
  logic [7:0]   word_length;
  logic [7:0]   word_length_next;
  logic [7:0]   limit;
  logic [8:0]   len;
  logic         is_space;
  logic         is_letter;
  logic         is_digit;
  logic         cut;
  cswt_result_t fresh_res;
  logic         fresh_present;
  mode_t        fresh_mode;
  logic [7:0]   fresh_length;

  assign limit     = (word_limit == 8'd0) ? 8'd1 : word_limit;
  assign is_space  = (in_char == 8'd32) || (in_char >= 8'd9 && in_char <= 8'd13);
  assign is_letter = (in_char >= 8'd65 && in_char <= 8'd90) ||
                     (in_char >= 8'd97 && in_char <= 8'd122);
  assign is_digit  = (in_char >= 8'd48 && in_char <= 8'd57);
  assign len       = {1'b0, word_length} + 9'd1;
  assign cut       = len >= {1'b0, limit};

  always_comb begin
    fresh_res     = '{ch: in_char, char_valid: 1'b1, kind: K_OTHER,
                      start_mark: 1'b1, end_mark: 1'b1, done: 1'b0};
    fresh_present = 1'b1;
    fresh_mode    = M_IDLE;
    fresh_length  = 8'd0;
    if (is_space) begin
      fresh_present = 1'b0;
    end else if (is_letter || in_char == CH_UNDERSCORE || in_char == CH_HASH) begin
      fresh_res.kind = K_IDENT;
      if (limit > 8'd1) begin
        fresh_res.end_mark = 1'b0;
        fresh_mode         = M_IDENT;
        fresh_length       = 8'd1;
      end
    end else if (in_char == CH_QUOTE) begin
      fresh_res.kind = K_CHARLIT;
      fresh_mode     = M_CHARLIT;
    end else if (in_char == CH_DQUOTE) begin
      fresh_res.kind = K_STRING;
      fresh_mode     = M_STRING;
    end else if (in_char == CH_SLASH) begin
      fresh_res.kind = K_SLASH;
      fresh_mode     = M_SLASH;
    end
  end

  always_comb begin
    mode_next        = mode;
    word_length_next = word_length;
    entry            = '{marker: 1'b0, present: 1'b0, res: fresh_res};
    if (end_of_input) begin
      entry.present = 1'b1;
      entry.res     = '{ch: 8'd0, char_valid: 1'b0, kind: K_IDENT, start_mark: 1'b0,
                        end_mark: (mode == M_IDENT), done: 1'b1};
      mode_next        = M_IDLE;
      word_length_next = 8'd0;
    end else begin
      unique case (mode)
        M_IDENT: begin
          if (is_letter || is_digit || in_char == CH_UNDERSCORE) begin
            entry.present = 1'b1;
            entry.res     = '{ch: in_char, char_valid: 1'b1, kind: K_IDENT,
                              start_mark: 1'b0, end_mark: cut, done: 1'b0};
            if (cut) begin
              mode_next        = M_IDLE;
              word_length_next = 8'd0;
            end else begin
              word_length_next = len[7:0];
            end
          end else begin
            entry.marker     = 1'b1;
            entry.present    = fresh_present;
            mode_next        = fresh_mode;
            word_length_next = fresh_length;
          end
        end
        M_CHARLIT: begin
          if (in_char == CH_QUOTE) mode_next = M_IDLE;
        end
        M_STRING: begin
          if (in_char == CH_BACKSLASH) mode_next = M_STR_ESC;
          else if (in_char == CH_DQUOTE) mode_next = M_IDLE;
        end
        M_STR_ESC: begin
          mode_next = M_STRING;
        end
        M_SLASH: begin
          if (in_char == CH_STAR) begin
            mode_next = M_COMMENT;
          end else begin
            entry.present = fresh_present;
            mode_next     = fresh_mode;
            if (fresh_mode == M_IDENT || fresh_present) word_length_next = fresh_length;
          end
        end
        M_COMMENT: begin
          if (in_char == CH_STAR) mode_next = M_COMMENT_STAR;
        end
        M_COMMENT_STAR: begin
          if (in_char == CH_SLASH) mode_next = M_IDLE;
          else if (in_char != CH_STAR) mode_next = M_COMMENT;
        end
        default: begin
          entry.present    = fresh_present;
          mode_next        = fresh_mode;
          word_length_next = fresh_length;
        end
      endcase
    end
  end

  assign push = accept && (entry.marker || entry.present);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= M_IDLE;
      word_length <= 8'd0;
    end else if (accept) begin
      mode        <= mode_next;
      word_length <= word_length_next;
    end
  end

endmodule

/* hw/rtl/cswt_queue.sv */
// Short entry queue between the front and the back part.
module cswt_queue #(
  parameter int DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  cswt_pkg::cswt_entry_t wr_entry,
  input  logic                  pop,
  output cswt_pkg::cswt_entry_t rd_entry,
  output logic                  full,
  output logic                  not_empty
);
  import cswt_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cswt_entry_t       slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign rd_entry  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wr_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (pop) rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      if (push && !pop) count <= count + CNT_W'(1);
      else if (pop && !push) count <= count - CNT_W'(1);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH)) else $error("queue count beyond depth");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    full && !pop |-> !push) else $error("push into full queue");

endmodule

/* hw/rtl/cswt_back.sv */
// Back part: splits queue entries into result beats and holds the output register.
module cswt_back (
  input  logic                  clk,
  input  logic                  rst,
  input  cswt_pkg::cswt_entry_t head,
  input  logic                  head_valid,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output cswt_pkg::cswt_result_t out_res
);
  import cswt_pkg::*;

  logic         pend;
  cswt_result_t held;
  logic         load;

  assign load = !out_valid || !out_stall;
  assign pop  = load && !pend && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend      <= 1'b0;
    end else if (load) begin
      if (pend) begin
        out_res   <= held;
        pend      <= 1'b0;
        out_valid <= 1'b1;
      end else if (head_valid) begin
        out_valid <= 1'b1;
        if (head.marker) begin
          out_res <= MARKER_RESULT;
          held    <= head.res;
          pend    <= head.present;
        end else begin
          out_res <= head.res;
        end
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  a_pend_shown: assert property (@(posedge clk) disable iff (rst)
    pend |-> out_valid) else $error("pending result without a shown marker");
  a_marker_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_res.char_valid && !out_res.done |->
      out_res.end_mark && out_res.kind == K_IDENT && out_res.ch == 8'd0)
    else $error("byteless beat is not a word end marker");

endmodule

/* hw/rtl/c_source_word_tokenizer_core.sv */
// Top level of the C source word tokenizer.
// Input channel: in_valid/in_stall carries one source byte (in_char) or an
// end mark (end_of_input) per beat. Output channel: out_valid/out_stall
// carries one result beat: out_char, char_valid, word_kind, word_start,
// word_end and input_done. Each input beat gives zero, one or two results.
// The configuration channel cfg_valid/cfg_ready writes word_limit from
// cfg_data; it is always ready and should be used only while the block idles.
// The front takes one byte per cycle while the queue is not full and writes
// at most one queue entry per byte; the back sends one result per cycle while
// the receiver does not stall, so a byte that ends an identifier and starts a
// new word gives two result beats. A result passes through the queue and the
// output register. When the receiver stalls, the output beat holds and the queue
// of QUEUE_DEPTH entries fills; in_stall rises once it is full. Reset clears
// the lexer mode, the queue and out_valid, and sets word_limit to 100.
module c_source_word_tokenizer_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char,
  input  logic       end_of_input,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       char_valid,
  output logic [2:0] word_kind,
  output logic       word_start,
  output logic       word_end,
  output logic       input_done,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);
  import cswt_pkg::*;

  logic         [7:0] word_limit;
  logic               accept;
  logic               push;
  logic               pop;
  logic               full;
  logic               not_empty;
  cswt_entry_t        wr_entry;
  cswt_entry_t        head;
  cswt_result_t       out_res;

  assign cfg_ready = 1'b1;
  assign in_stall  = full;
  assign accept    = in_valid && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_limit <= WORD_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      word_limit <= cfg_data;
    end
  end

  cswt_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .in_char      (in_char),
    .end_of_input (end_of_input),
    .word_limit   (word_limit),
    .push         (push),
    .entry        (wr_entry)
  );

  cswt_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_entry  (wr_entry),
    .pop       (pop),
    .rd_entry  (head),
    .full      (full),
    .not_empty (not_empty)
  );

  cswt_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (not_empty),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_res    (out_res)
  );

  assign out_char   = out_res.ch;
  assign char_valid = out_res.char_valid;
  assign word_kind  = out_res.kind;
  assign word_start = out_res.start_mark;
  assign word_end   = out_res.end_mark;
  assign input_done = out_res.done;

endmodule
